### sv/tktp_pkg.sv
`timescale 1ns / 1ps

package tktp_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned QDepth = 8;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned NWrW   = $clog2(MaxRes + 1);

  localparam logic [7:0]  KeySepRst  = 8'd9;
  localparam logic [7:0]  RecSepRst  = 8'd13;
  localparam logic [7:0]  QuoteRst   = 8'd34;
  localparam logic [31:0] HashSeedRst = 32'd69069;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_SEP   = 3'd0,
    CFG_REC_SEP   = 3'd1,
    CFG_QUOTE     = 3'd2,
    CFG_HASH_SEED = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  key_sep;
    logic [7:0]  rec_sep;
    logic [7:0]  quote;
    logic [31:0] hash_seed;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        in_text;
    logic        field_end;
    logic        truncated;
    logic        last;
    logic        reload;
    logic [31:0] seed;
  } ent_t;

  function automatic ent_t mk_byte(logic [7:0] b, logic it);
    ent_t e;
    e            = '0;
    e.out_byte   = b;
    e.byte_valid = 1'b1;
    e.in_text    = it;
    return e;
  endfunction

  function automatic ent_t mk_end(logic it, logic trunc);
    ent_t e;
    e           = '0;
    e.in_text   = it;
    e.field_end = 1'b1;
    e.truncated = trunc;
    return e;
  endfunction

endpackage

### sv/tsv_key_text_record_parser.sv
`timescale 1ns / 1ps
// path: a byte's result words are written into the word queue, then into the output register
// throughput: one byte per cycle while each byte yields at most one word and the output
//   is not stalled; the output register sends one word per cycle while out_stall_i is low
// an 8-entry word queue between parser and output stalls input when fewer than 4 are free
// reset: registers to defaults, parser at key field start, queue and output empty

module tsv_key_text_record_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            end_of_buffer_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic                            byte_valid_o,
  output logic                            in_text_field_o,
  output logic                            field_end_o,
  output logic [31:0]                     key_hash_o,
  output logic                            truncated_o,
  output logic                            last_of_run_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tktp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  tktp_pkg::cfg_t                  cfg_q;
  tktp_pkg::ent_t                  ent [tktp_pkg::MaxRes];
  logic [tktp_pkg::NWrW-1:0]       nwr;
  tktp_pkg::ent_t                  q_q [tktp_pkg::QDepth];
  logic [tktp_pkg::QAw-1:0]        wp_q, rp_q;
  logic [tktp_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                            in_fire, pop;
  tktp_pkg::ent_t                  head;
  logic [31:0]                     hash_q, hash_d, h0, prod;
  logic                            stop_q, stop_d, st0;
  logic                            out_valid_q;
  logic [7:0]                      out_byte_q;
  logic                            byte_valid_q, in_text_q, field_end_q, trunc_q, last_q;
  logic [31:0]                     key_hash_q, key_hash_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_sep   <= tktp_pkg::KeySepRst;
      cfg_q.rec_sep   <= tktp_pkg::RecSepRst;
      cfg_q.quote     <= tktp_pkg::QuoteRst;
      cfg_q.hash_seed <= tktp_pkg::HashSeedRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tktp_pkg::CFG_KEY_SEP:   cfg_q.key_sep   <= cfg_data_i[7:0];
        tktp_pkg::CFG_REC_SEP:   cfg_q.rec_sep   <= cfg_data_i[7:0];
        tktp_pkg::CFG_QUOTE:     cfg_q.quote     <= cfg_data_i[7:0];
        tktp_pkg::CFG_HASH_SEED: cfg_q.hash_seed <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = cnt_q > tktp_pkg::CntW'(tktp_pkg::QDepth - tktp_pkg::MaxRes);
  assign in_fire    = in_valid_i && !in_stall_o;

  tktp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .in_byte_i (in_byte_i),
    .eob_i     (end_of_buffer_i),
    .cfg_i     (cfg_q),
    .ent_o     (ent),
    .nwr_o     (nwr)
  );

  assign pop   = (cnt_q != '0) && (!out_valid_q || !out_stall_i);
  assign head  = q_q[rp_q];
  assign cnt_d = cnt_q + tktp_pkg::CntW'(nwr) - tktp_pkg::CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < tktp_pkg::MaxRes; i++) begin
      if (tktp_pkg::NWrW'(i) < nwr) begin
        q_q[tktp_pkg::QAw'(wp_q + tktp_pkg::QAw'(i))] <= ent[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= tktp_pkg::QAw'(wp_q + tktp_pkg::QAw'(nwr));
      rp_q  <= tktp_pkg::QAw'(rp_q + tktp_pkg::QAw'(pop));
      cnt_q <= cnt_d;
    end
  end

  // key hash advances as words leave the queue
  assign h0   = head.reload ? head.seed : hash_q;
  assign st0  = head.reload ? 1'b0 : stop_q;
  assign prod = h0 * {{24{head.out_byte[7]}}, head.out_byte} + 32'd1;

  always_comb begin
    hash_d     = hash_q;
    stop_d     = stop_q;
    key_hash_d = '0;
    if (pop) begin
      hash_d = h0;
      stop_d = st0;
      if (head.byte_valid && !head.in_text && !st0) begin
        if (head.out_byte == 8'd0) begin
          stop_d = 1'b1;
        end else begin
          hash_d = prod;
        end
      end
      if (head.field_end && !head.in_text) begin
        key_hash_d = h0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= tktp_pkg::HashSeedRst;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      stop_q <= stop_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q   <= head.out_byte;
      byte_valid_q <= head.byte_valid;
      in_text_q    <= head.in_text;
      field_end_q  <= head.field_end;
      trunc_q      <= head.truncated;
      last_q       <= head.last;
      key_hash_q   <= key_hash_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign byte_valid_o    = byte_valid_q;
  assign in_text_field_o = in_text_q;
  assign field_end_o     = field_end_q;
  assign key_hash_o      = key_hash_q;
  assign truncated_o     = trunc_q;
  assign last_of_run_o   = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tktp_pkg::CntW'(tktp_pkg::QDepth))
    else $error("word queue overflow");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> cnt_q + tktp_pkg::CntW'(tktp_pkg::MaxRes) <= tktp_pkg::CntW'(tktp_pkg::QDepth))
    else $error("byte accepted without room for its words");

  a_no_words_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |-> nwr == '0)
    else $error("parser wrote words without an accepted byte");

  a_hash_only_key_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !(field_end_q && !in_text_q) |-> key_hash_q == '0)
    else $error("hash shown outside a key field end");

  a_pop_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> rp_q == tktp_pkg::QAw'($past(rp_q) + 1'b1))
    else $error("read pointer out of step");

endmodule

### sv/tktp_parse.sv
`timescale 1ns / 1ps

module tktp_parse (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     eob_i,
  input  tktp_pkg::cfg_t           cfg_i,
  output tktp_pkg::ent_t           ent_o [tktp_pkg::MaxRes],
  output logic [tktp_pkg::NWrW-1:0] nwr_o
);

  logic        in_text_q, in_text_d;
  logic        afs_q, afs_d;
  logic        fq_q, fq_d;
  logic        qp_q, qp_d;
  logic        hv_q, hv_d;
  logic [7:0]  hb_q, hb_d;
  logic        skip_q, skip_d;
  logic        rl_pend_q, rl_pend_d;
  logic [31:0] rl_seed_q, rl_seed_d;

  always_comb begin : p_parse
    tktp_pkg::ent_t            ent [tktp_pkg::MaxRes];
    logic [tktp_pkg::NWrW-1:0] n;
    logic                      it, afs, fq, qp, hv, skip, reload, done;
    logic [7:0]                hb, sep, b, qb;
    ent    = '{default: '0};
    n      = '0;
    it     = in_text_q;
    afs    = afs_q;
    fq     = fq_q;
    qp     = qp_q;
    hv     = hv_q;
    hb     = hb_q;
    skip   = skip_q;
    reload = 1'b0;
    done   = 1'b0;
    b      = in_byte_i;
    qb     = cfg_i.quote;
    sep    = in_text_q ? cfg_i.rec_sep : cfg_i.key_sep;
    rl_pend_d = rl_pend_q;
    rl_seed_d = rl_seed_q;
    if (fire_i) begin
      if (skip) begin
        skip = 1'b0;
      end else begin
        if (afs) begin
          if (!it) begin
            reload = 1'b1;
          end
          afs = 1'b0;
          if (b == qb) begin
            fq   = 1'b1;
            done = 1'b1;
          end
        end
        if (!done && qp) begin
          qp = 1'b0;
          // pending quote goes out as a character
          if (fq) begin
            if (hv) begin
              ent[n[1:0]] = tktp_pkg::mk_byte(hb, it);
              n = n + 1'b1;
            end
            hb = qb;
            hv = 1'b1;
          end else begin
            ent[n[1:0]] = tktp_pkg::mk_byte(qb, it);
            n = n + 1'b1;
          end
          if (b == qb) begin
            done = 1'b1;
          end
        end
        if (!done) begin
          if (b == sep) begin
            ent[n[1:0]] = tktp_pkg::mk_end(it, 1'b0);
            n   = n + 1'b1;
            afs = 1'b1;
            fq  = 1'b0;
            qp  = 1'b0;
            hv  = 1'b0;
            hb  = '0;
            if (!it) begin
              it = 1'b1;
            end else begin
              it   = 1'b0;
              skip = 1'b1;
            end
          end else if (b == qb) begin
            qp = 1'b1;
          end else if (fq) begin
            if (hv) begin
              ent[n[1:0]] = tktp_pkg::mk_byte(hb, it);
              n = n + 1'b1;
            end
            hb = b;
            hv = 1'b1;
          end else begin
            ent[n[1:0]] = tktp_pkg::mk_byte(b, it);
            n = n + 1'b1;
          end
        end
      end
      if (eob_i) begin
        if (it || !afs) begin
          if (qp) begin
            qp = 1'b0;
            if (fq) begin
              if (hv) begin
                ent[n[1:0]] = tktp_pkg::mk_byte(hb, it);
                n = n + 1'b1;
              end
              hb = qb;
              hv = 1'b1;
            end else begin
              ent[n[1:0]] = tktp_pkg::mk_byte(qb, it);
              n = n + 1'b1;
            end
          end
          if (hv) begin
            ent[n[1:0]] = tktp_pkg::mk_byte(hb, it);
            n = n + 1'b1;
          end
          ent[n[1:0]] = tktp_pkg::mk_end(it, 1'b1);
          n = n + 1'b1;
        end
        afs  = 1'b1;
        fq   = 1'b0;
        qp   = 1'b0;
        hv   = 1'b0;
        hb   = '0;
        it   = 1'b0;
        skip = 1'b0;
      end
      // seed reload rides on the first word of the step
      if (n != '0) begin
        ent[0].reload = rl_pend_q || reload;
        ent[0].seed   = reload ? cfg_i.hash_seed : rl_seed_q;
        ent[n[1:0] - 2'd1].last = 1'b1;
        rl_pend_d = 1'b0;
      end else if (reload) begin
        rl_pend_d = 1'b1;
        rl_seed_d = cfg_i.hash_seed;
      end
    end
    in_text_d = it;
    afs_d     = afs;
    fq_d      = fq;
    qp_d      = qp;
    hv_d      = hv;
    hb_d      = hb;
    skip_d    = skip;
    ent_o     = ent;
    nwr_o     = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_text_q <= 1'b0;
      afs_q     <= 1'b1;
      fq_q      <= 1'b0;
      qp_q      <= 1'b0;
      hv_q      <= 1'b0;
      hb_q      <= '0;
      skip_q    <= 1'b0;
      rl_pend_q <= 1'b0;
      rl_seed_q <= tktp_pkg::HashSeedRst;
    end else begin
      in_text_q <= in_text_d;
      afs_q     <= afs_d;
      fq_q      <= fq_d;
      qp_q      <= qp_d;
      hv_q      <= hv_d;
      hb_q      <= hb_d;
      skip_q    <= skip_d;
      rl_pend_q <= rl_pend_d;
      rl_seed_q <= rl_seed_d;
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseBytes = 50;
  localparam logic [7:0]  LineFeed   = 8'h0a;

  // {end_of_buffer, byte}, run with the reset register values
  localparam logic [8:0] DirSeq [24] = '{
    9'h022, 9'h000, 9'h080, 9'h022, 9'h022, 9'h0ff, 9'h022, 9'h009,
    9'h07f, 9'h022, 9'h061, 9'h00d, 9'h10a,
    9'h022, 9'h009, 9'h022, 9'h078, 9'h122,
    9'h041, 9'h109,
    9'h031, 9'h009, 9'h10d,
    9'h135
  };

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        in_text_field;
    logic        field_end;
    logic [31:0] key_hash;
    logic        truncated;
    logic        last_of_run;
  } record_word_t;

  class record_parse_scoreboard;
    bit [7:0]     key_sep, rec_sep, quote;
    bit [31:0]    seed;
    bit           in_text, at_start, quoted, quote_pend, held_vld, skip_lf, hash_stop;
    bit [7:0]     held;
    bit [31:0]    hash;
    record_word_t step_words[$];
    record_word_t expected_words[$];
    int           errors;

    function void emit_word(bit [7:0] b, bit vld, bit fend, bit [31:0] h, bit trunc);
      record_word_t w;
      w.out_byte      = vld ? b : 8'h00;
      w.byte_valid    = vld;
      w.in_text_field = in_text;
      w.field_end     = fend;
      w.key_hash      = h;
      w.truncated     = trunc;
      w.last_of_run   = 1'b0;
      step_words.push_back(w);
    endfunction

    function void push_char(bit [7:0] b);
      if (!in_text && !hash_stop) begin
        if (b == 8'h00) hash_stop = 1'b1;
        else hash = hash * {{24{b[7]}}, b} + 32'd1;
      end
      emit_word(b, 1'b1, 1'b0, 32'd0, 1'b0);
    endfunction

    // quoted fields hold the newest char back so the closing one can be dropped
    function void produce_char(bit [7:0] b);
      if (quoted) begin
        if (held_vld) push_char(held);
        held     = b;
        held_vld = 1'b1;
      end else begin
        push_char(b);
      end
    endfunction

    function void clear_field();
      at_start   = 1'b1;
      quoted     = 1'b0;
      quote_pend = 1'b0;
      held_vld   = 1'b0;
      held       = 8'h00;
    endfunction

    function void close_field(bit trunc);
      if (held_vld && trunc) push_char(held);
      emit_word(8'h00, 1'b0, 1'b1, in_text ? 32'd0 : hash, trunc);
      clear_field();
      if (!trunc) begin
        if (!in_text) begin
          in_text = 1'b1;
        end else begin
          in_text = 1'b0;
          skip_lf = 1'b1;
        end
      end
    endfunction

    function void restart_parse();
      clear_field();
      in_text   = 1'b0;
      skip_lf   = 1'b0;
      hash_stop = 1'b0;
    endfunction

    function void reset_state();
      key_sep = tktp_pkg::KeySepRst;
      rec_sep = tktp_pkg::RecSepRst;
      quote   = tktp_pkg::QuoteRst;
      seed    = tktp_pkg::HashSeedRst;
      restart_parse();
      hash = seed;
      expected_words.delete();
      errors = 0;
    endfunction

    function void set_register(tktp_pkg::cfg_idx_e idx, bit [31:0] d);
      case (idx)
        tktp_pkg::CFG_KEY_SEP:   key_sep = d[7:0];
        tktp_pkg::CFG_REC_SEP:   rec_sep = d[7:0];
        tktp_pkg::CFG_QUOTE:     quote   = d[7:0];
        tktp_pkg::CFG_HASH_SEED: seed    = d;
        default: ;
      endcase
    endfunction

    function void note_byte(bit [7:0] b, bit eob);
      bit           done;
      bit [7:0]     sep;
      record_word_t w;
      step_words.delete();
      done = 1'b0;
      if (skip_lf) begin
        skip_lf = 1'b0;
      end else begin
        sep = in_text ? rec_sep : key_sep;
        if (at_start) begin
          if (!in_text) begin
            hash      = seed;
            hash_stop = 1'b0;
          end
          at_start = 1'b0;
          if (b == quote) begin
            quoted = 1'b1;
            done   = 1'b1;
          end
        end
        if (!done && quote_pend) begin
          quote_pend = 1'b0;
          produce_char(quote);
          if (b == quote) done = 1'b1;
        end
        if (!done) begin
          if (b == sep) close_field(1'b0);
          else if (b == quote) quote_pend = 1'b1;
          else produce_char(b);
        end
      end
      if (eob) begin
        if (in_text || !at_start) begin
          if (quote_pend) begin
            quote_pend = 1'b0;
            produce_char(quote);
          end
          close_field(1'b1);
        end
        restart_parse();
      end
      foreach (step_words[i]) begin
        w             = step_words[i];
        w.last_of_run = (i == step_words.size() - 1);
        expected_words.push_back(w);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_word(record_word_t got);
      record_word_t want;
      if (expected_words.size() == 0) begin
        report("word with no expectation");
      end else begin
        want = expected_words.pop_front();
        compare_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
        compare_field("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
        compare_field("in_text_field", 32'(got.in_text_field), 32'(want.in_text_field));
        compare_field("field_end", 32'(got.field_end), 32'(want.field_end));
        compare_field("key_hash", got.key_hash, want.key_hash);
        compare_field("truncated", 32'(got.truncated), 32'(want.truncated));
        compare_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [7:0]                    in_byte_i;
  logic                          end_of_buffer_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [7:0]                    out_byte_o;
  logic                          byte_valid_o;
  logic                          in_text_field_o;
  logic                          field_end_o;
  logic [31:0]                   key_hash_o;
  logic                          truncated_o;
  logic                          last_of_run_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [tktp_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [31:0]                   cfg_data_i;

  logic                hold_off    = 1'b0;
  int unsigned         stall_pct   = 0;
  int unsigned         idle_pct    = 0;
  int unsigned         quiet_count = 0;
  logic [7:0]          record_q[$];

  record_parse_scoreboard sb = new;

  tsv_key_text_record_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .in_text_field_o (in_text_field_o),
    .field_end_o     (field_end_o),
    .key_hash_o      (key_hash_o),
    .truncated_o     (truncated_o),
    .last_of_run_o   (last_of_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk_i) begin : monitor
    record_word_t got;
    bit           moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_byte(in_byte_i, end_of_buffer_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.out_byte      = out_byte_o;
        got.byte_valid    = byte_valid_o;
        got.in_text_field = in_text_field_o;
        got.field_end     = field_end_o;
        got.key_hash      = key_hash_o;
        got.truncated     = truncated_o;
        got.last_of_run   = last_of_run_o;
        sb.check_word(got);
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
    end
    quiet_count = moved ? 0 : quiet_count + 1;
    if (quiet_count == StallLimit) begin
      $display("tsv_key_text_record_parser test failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic eob);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_buffer_i <= eob;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_register(tktp_pkg::cfg_idx_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, d);
  endtask

  task automatic configure(logic [7:0] ks, logic [7:0] rs, logic [7:0] q, logic [31:0] seed);
    write_register(tktp_pkg::CFG_KEY_SEP, {24'h0, ks});
    write_register(tktp_pkg::CFG_REC_SEP, {24'h0, rs});
    write_register(tktp_pkg::CFG_QUOTE, {24'h0, q});
    write_register(tktp_pkg::CFG_HASH_SEED, seed);
    cfg_valid_i <= 1'b0;
  endtask

  // idle means no word pending and the pipe flushed of bytes with no result
  task automatic drain();
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic hold_receiver(int unsigned cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off <= 1'b0;
  endtask

  function automatic void add_field(logic [7:0] sep);
    bit          quoted;
    int unsigned len;
    int unsigned r;
    logic [7:0]  c;
    quoted = ($urandom_range(2) == 0);
    len    = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(6);
    if (quoted) record_q.push_back(sb.quote);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 10) c = sb.quote;
      else if (r < 15) c = 8'h00;
      else if (r < 20) c = 8'h80 | 8'($urandom_range(127));
      else c = 8'($urandom_range(255));
      if (c == sep) c = c ^ 8'h01;
      record_q.push_back(c);
      if (c == sb.quote && $urandom_range(1) == 1) record_q.push_back(c);
    end
    if (quoted) record_q.push_back(sb.quote);
    record_q.push_back(sep);
  endfunction

  task automatic run_records(int unsigned n_bytes);
    int unsigned sent;
    bit          eob;
    sent = 0;
    while (sent < n_bytes) begin
      record_q.delete();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 12)) record_q.push_back(8'($urandom_range(255)));
      end else begin
        add_field(sb.key_sep);
        add_field(sb.rec_sep);
        record_q.push_back(LineFeed);
      end
      foreach (record_q[i]) begin
        eob = (i == record_q.size() - 1 && $urandom_range(3) == 0) ||
              ($urandom_range(49) == 0);
        send_byte(record_q[i], eob);
        sent++;
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_byte_i       = 8'h00;
    end_of_buffer_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = tktp_pkg::CFG_KEY_SEP;
    cfg_data_i      = 32'd0;
    sb.reset_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirSeq[i]) send_byte(DirSeq[i][7:0], DirSeq[i][8]);
    in_valid_i <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          configure(8'h00, 8'hff, 8'h80, 32'h0);
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          configure(8'hff, 8'h00, 8'hff, 32'hffff_ffff);
          idle_pct  = 49;
          stall_pct <= 0;
        end
        2: begin
          configure(8'($urandom_range(255)), 8'h5c, 8'h5c, $urandom);
          idle_pct  = 0;
          stall_pct <= 49;
        end
        3: begin
          configure(tktp_pkg::KeySepRst, tktp_pkg::RecSepRst, tktp_pkg::QuoteRst,
                    tktp_pkg::HashSeedRst);
          idle_pct  = 6;
          stall_pct <= 6;
        end
        4: begin
          configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), $urandom);
          idle_pct  = 0;
          stall_pct <= 0;
          fork
            hold_receiver(HoldCycles);
          join_none
        end
        default: begin
          configure(8'h2c, 8'h2c, 8'($urandom_range(255)), $urandom);
          idle_pct  = 0;
          stall_pct <= 0;
        end
      endcase
      run_records(PhaseBytes);
    end

    drain();
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("tsv_key_text_record_parser test passed");
    end else begin
      $display("tsv_key_text_record_parser test failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/tktp_pkg.sv
sv/tktp_parse.sv
sv/tsv_key_text_record_parser.sv
sim/tb_top.sv
